// File: rtl/csa_pkg.sv
`default_nettype none
package csa_pkg;

  localparam int CovW      = 16;
  localparam int CntW      = 32;
  localparam int SumW      = 64;
  localparam int NumThresh = 12;

  localparam logic [CntW-1:0] CntMax = '1;

  // depth levels counted per domain, lowest first
  localparam logic [CovW-1:0] ThreshLevels [NumThresh] = '{
    16'd1, 16'd5, 16'd10, 16'd15, 16'd20, 16'd30,
    16'd40, 16'd50, 16'd60, 16'd100, 16'd500, 16'd1000
  };

  typedef struct packed {
    logic [CovW-1:0] coverage;
    logic            mode;
  } in_item_t;

  typedef struct packed {
    logic            covered;
    logic [CovW-1:0] max_seen;
    logic [CntW-1:0] max_base_count;
  } out_item_t;

  // classified item handed from front to back
  typedef struct packed {
    logic                 mode;
    logic [CovW-1:0]      coverage;
    logic [NumThresh-1:0] thresh_hit;
  } work_t;

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
    sat_inc = (v == CntMax) ? v : v + CntW'(1);
  endfunction

  function automatic logic [NumThresh-1:0] thresh_mask(input logic [CovW-1:0] cov);
    logic [NumThresh-1:0] m;
    for (int k = 0; k < NumThresh; k++) begin
      m[k] = (cov >= ThreshLevels[k]);
    end
    thresh_mask = m;
  endfunction

endpackage
`default_nettype wire

// File: rtl/csa_fifo.sv
`default_nettype none
module csa_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output logic              empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: rtl/csa_front.sv
`default_nettype none
module csa_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              accept,
  input  wire csa_pkg::in_item_t item,
  output csa_pkg::out_item_t     result,
  output csa_pkg::work_t         work
);

  logic [csa_pkg::CovW-1:0] peak_cov_r, peak_cov_nxt;
  logic [csa_pkg::CntW-1:0] peak_cnt_r, peak_cnt_nxt;

  // peak tracking across both domains
  always_comb begin
    peak_cov_nxt = peak_cov_r;
    peak_cnt_nxt = peak_cnt_r;
    if (item.coverage > peak_cov_r) begin
      peak_cov_nxt = item.coverage;
      peak_cnt_nxt = csa_pkg::CntW'(1);
    end else if (item.coverage == peak_cov_r) begin
      peak_cnt_nxt = csa_pkg::sat_inc(peak_cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_cov_r <= '0;
      peak_cnt_r <= '0;
    end else if (accept) begin
      peak_cov_r <= peak_cov_nxt;
      peak_cnt_r <= peak_cnt_nxt;
    end
  end

  always_comb begin
    result.covered        = (item.coverage != '0);
    result.max_seen       = peak_cov_nxt;
    result.max_base_count = peak_cnt_nxt;
    work.mode             = item.mode;
    work.coverage         = item.coverage;
    work.thresh_hit       = csa_pkg::thresh_mask(item.coverage);
  end

endmodule
`default_nettype wire

// File: rtl/csa_back.sv
`default_nettype none
module csa_back #(
  parameter int HIST_BINS = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           work_valid,
  input  wire csa_pkg::work_t work,
  output logic                work_take,
  output logic                clearing
);

  localparam int BW = $clog2(HIST_BINS);
  localparam int AW = BW + 1;
  localparam int HIST_DEPTH = 2 ** AW;
  localparam logic [csa_pkg::CovW:0] LastBin = (csa_pkg::CovW + 1)'(HIST_BINS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic [AW:0] clr_idx_r, clr_idx_nxt;

  logic [csa_pkg::CntW-1:0] hist_mem [HIST_DEPTH];
  logic [csa_pkg::CntW-1:0] rd_data_r;

  logic [csa_pkg::CntW-1:0] thr_cnt_r [2][csa_pkg::NumThresh];
  logic [csa_pkg::SumW-1:0] sum_r [2];

  logic [BW-1:0]            bin;
  logic [AW-1:0]            rd_addr;
  logic                     s1_valid_r;
  logic [AW-1:0]            s1_addr_r;
  logic                     wr_valid_r;
  logic [AW-1:0]            wr_addr_r;
  logic [csa_pkg::CntW-1:0] wr_data_r;
  logic                     we;
  logic [AW-1:0]            wa;
  logic [csa_pkg::CntW-1:0] wd, old_val;

  assign clearing  = (state_r == ST_CLEAR);
  assign work_take = work_valid && (state_r == ST_RUN);

  // deep bases land in the last bin
  assign bin = ({1'b0, work.coverage} >= LastBin) ? LastBin[BW-1:0] : work.coverage[BW-1:0];
  assign rd_addr = {work.mode, bin};

  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    case (state_r)
      ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + (AW + 1)'(1);
        if (clr_idx_r == (AW + 1)'(HIST_DEPTH - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN:  state_nxt = ST_RUN;
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // read-modify-write; the one write in flight is forwarded
  assign old_val = (wr_valid_r && wr_addr_r == s1_addr_r) ? wr_data_r : rd_data_r;

  always_comb begin
    we = 1'b0;
    wa = s1_addr_r;
    wd = csa_pkg::sat_inc(old_val);
    if (clearing) begin
      we = 1'b1;
      wa = clr_idx_r[AW-1:0];
      wd = '0;
    end else if (s1_valid_r) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= hist_mem[rd_addr];
    if (we) begin
      hist_mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= rd_addr;
    wr_addr_r <= wa;
    wr_data_r <= wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      wr_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= work_take;
      wr_valid_r <= we;
    end
  end

  // threshold counters and coverage totals per domain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int d = 0; d < 2; d++) begin
        sum_r[d] <= '0;
        for (int k = 0; k < csa_pkg::NumThresh; k++) begin
          thr_cnt_r[d][k] <= '0;
        end
      end
    end else if (work_take) begin
      sum_r[work.mode] <= sum_r[work.mode] + csa_pkg::SumW'(work.coverage);
      for (int k = 0; k < csa_pkg::NumThresh; k++) begin
        if (work.thresh_hit[k]) begin
          thr_cnt_r[work.mode][k] <= csa_pkg::sat_inc(thr_cnt_r[work.mode][k]);
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/coverage_stats_accumulator.sv
`default_nettype none
// coverage statistics accumulator: takes one base's coverage depth and a domain
// select (0 genome, 1 target) per transfer and returns one result per item: a
// covered flag, the peak coverage so far and the number of bases at that peak.
// internally it keeps a per-domain depth histogram (deep bases in the last bin),
// twelve per-domain threshold counters and a 64-bit coverage total per domain.
// rate: one item per clock while full stays low; each result is written into
// the result queue at its transfer. the histogram read-modify-write is a
// two-stage pipeline on one read and one write port of the memory, with forwarding.
// after reset, full stays high for a clearing sweep of all 2 * 2**clog2(HIST_BINS)
// entries (2048 by default) while the histogram memory is zeroed one entry per cycle.
module coverage_stats_accumulator #(
  parameter int HIST_BINS = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input queue side
  input  wire logic               push,
  output logic                    full,
  input  wire csa_pkg::in_item_t  in_data,
  // result queue side
  output logic                    empty,
  input  wire logic               pop,
  output csa_pkg::out_item_t      out_data
);

  localparam int OutW  = $bits(csa_pkg::out_item_t);
  localparam int WorkW = $bits(csa_pkg::work_t);

  logic               accept;
  logic               res_full, work_full, work_empty;
  logic               work_take, clearing;
  csa_pkg::out_item_t result;
  csa_pkg::work_t     work_in, work_out;

  // an item transfers only when both the result and work queues have room
  assign full   = clearing || res_full || work_full;
  assign accept = push && !full;

  // front: peak tracking and classification
  csa_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .result (result),
    .work   (work_in)
  );

  // result queue: output register plus skid entry
  csa_fifo #(
    .W     (OutW),
    .DEPTH (2)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (result),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

  // work queue decoupling front from the statistics back end
  csa_fifo #(
    .W     (WorkW),
    .DEPTH (4)
  ) u_work_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept),
    .wr_data (work_in),
    .full    (work_full),
    .rd_en   (work_take),
    .rd_data (work_out),
    .empty   (work_empty)
  );

  // back: histogram, threshold counters, coverage totals
  csa_back #(
    .HIST_BINS (HIST_BINS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .work_valid (!work_empty),
    .work       (work_out),
    .work_take  (work_take),
    .clearing   (clearing)
  );

endmodule
`default_nettype wire
